### hdl/moving_average_window_filter_defines.svh
// ============================================================================
// Moving average window filter: assertion macros
// Concurrent assertion helpers shared by the filter's modules. The checks
// drop away when SYNTH is defined.
// ============================================================================
`ifndef MOVING_AVERAGE_WINDOW_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_WINDOW_FILTER_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every rising edge outside reset.
`define MAWF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a rising edge outside reset.
`define MAWF_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MAWF_ASSERT(label, clk, rst_n, prop, msg)
`define MAWF_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

### hdl/maf_pkg.sv
// ============================================================================
// Moving average window filter: package
// Shared widths, reset values and width helpers.
// ============================================================================
package maf_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int MEAN_W     = 24;
    localparam int FILL_W     = 5;
    localparam int WL_W       = 5;
    localparam int FRAC_W     = 8;

    // Default ring depth and window length after reset
    localparam int MAX_WINDOW = 16;
    localparam logic [WL_W-1:0] WL_RESET = 5'd5;

    // Depth of the queue between the front and back ends
    localparam int QUEUE_DEPTH = 2;

    // Quotient bits resolved per divider cycle
    localparam int DIV_STEP = 4;

    // Width of a count that can reach max_win
    function automatic int count_width(input int max_win);
        return $clog2(max_win + 1);
    endfunction

    // Width of a running sum of max_win samples
    function automatic int sum_width(input int max_win);
        return SAMPLE_W + $clog2(max_win + 1);
    endfunction

endpackage

### hdl/maf_queue.sv
// ============================================================================
// Moving average window filter: decoupling queue
// Small first-in first-out buffer between the front and back ends.
// ============================================================================
module maf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_room,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = maf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = i_push && o_room;
    assign pop_ok  = i_pop && o_valid;
    assign o_room  = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_store[r_rd_ptr];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    // Pointers wrap at the queue depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/maf_front.sv
// ============================================================================
// Moving average window filter: front end
// Accepts samples, keeps the sample ring and the running sum, and hands the
// updated sum and fill count to the queue.
// ============================================================================
`include "moving_average_window_filter_defines.svh"

module maf_front #(
    parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [maf_pkg::WL_W-1:0]                      i_cfg_data,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [maf_pkg::SAMPLE_W-1:0]                  i_sample,
    input  logic                                          i_q_room,
    output logic                                          o_q_push,
    output logic [maf_pkg::sum_width(MAX_WINDOW)-1:0]     o_q_sum,
    output logic [maf_pkg::count_width(MAX_WINDOW)-1:0]   o_q_count
);

    localparam int SW = maf_pkg::SAMPLE_W;
    localparam int CW = maf_pkg::count_width(MAX_WINDOW);
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int SUM_W = maf_pkg::sum_width(MAX_WINDOW);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state                    r_state;
    logic [maf_pkg::WL_W-1:0]  r_wl;
    logic [PW-1:0]             r_wp;
    logic [CW-1:0]             r_held;
    logic [SUM_W-1:0]          r_sum;
    logic [SW-1:0]             r_sample;
    logic [PW-1:0]             r_wp_use;
    logic                      r_full;
    logic [SW-1:0]             r_rd;
    logic [SW-1:0]             r_ring [MAX_WINDOW];

    logic [CW-1:0]             win;
    logic [PW-1:0]             n_wp_use;
    logic [CW-1:0]             wp_inc;
    logic [PW-1:0]             n_wp;
    logic [CW-1:0]             n_held;
    logic [SUM_W-1:0]          n_sum;
    logic                      accept;

    // Effective window: zero means one, anything above the ring depth saturates.
    always_comb begin
        if (32'(r_wl) > MAX_WINDOW) begin
            win = CW'(MAX_WINDOW);
        end else if (r_wl == '0) begin
            win = CW'(1);
        end else begin
            win = CW'(r_wl);
        end
    end

    assign o_ready = (r_state == S_IDLE) && i_q_room;
    assign accept  = i_valid && o_ready;

    // Slot taken by the incoming word; a stale pointer beyond the window restarts at zero.
    assign n_wp_use = (CW'(r_wp) >= win) ? '0 : r_wp;

    // Running sum, fill count and pointer after the word has gone in.
    always_comb begin
        n_sum  = r_sum - (r_full ? SUM_W'(r_rd) : '0) + SUM_W'(r_sample);
        n_held = r_full ? win : r_held + 1'b1;
        wp_inc = CW'(r_wp_use) + 1'b1;
        n_wp   = (wp_inc >= win) ? '0 : PW'(wp_inc);
    end

    assign o_q_push  = (r_state == S_UPDATE);
    assign o_q_sum   = n_sum;
    assign o_q_count = n_held;

    // Sample ring: the oldest word is read on acceptance and overwritten while in S_UPDATE.
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_ring[r_wp_use] <= r_sample;
        end
        if (accept) begin
            r_rd <= r_ring[n_wp_use];
        end
    end

    // Control state and history registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wl     <= maf_pkg::WL_RESET;
            r_wp     <= '0;
            r_held   <= '0;
            r_sum    <= '0;
            r_wp_use <= '0;
            r_full   <= 1'b0;
            r_sample <= '0;
        end else if (i_cfg_we) begin
            // A new window length empties the history.
            r_wl   <= i_cfg_data;
            r_wp   <= '0;
            r_held <= '0;
            r_sum  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample;
                        r_wp_use <= n_wp_use;
                        r_full   <= (r_held >= win);
                        r_state  <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_sum   <= n_sum;
                    r_held  <= n_held;
                    r_wp    <= n_wp;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The history never holds more words than the window allows.
    `MAWF_ASSERT(a_held_in_window, i_clk, i_rst_n, r_held <= win, "fill count beyond window")
    // The write pointer always lies inside the window.
    `MAWF_ASSERT(a_wp_in_window, i_clk, i_rst_n, CW'(r_wp) < win, "write pointer beyond window")
    // An accepted word is pushed to the queue on the next cycle when no configuration write comes with it.
    `MAWF_ASSERT(a_accept_push, i_clk, i_rst_n, (accept && !i_cfg_we) |=> o_q_push, "accepted word not pushed")

endmodule

### hdl/maf_back.sv
// ============================================================================
// Moving average window filter: back end
// Divides the scaled running sum by the fill count, several quotient bits per
// cycle, and holds the result in the output register.
// ============================================================================
`include "moving_average_window_filter_defines.svh"

module maf_back #(
    parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_valid,
    output logic                                          o_q_pop,
    input  logic [maf_pkg::sum_width(MAX_WINDOW)-1:0]     i_q_sum,
    input  logic [maf_pkg::count_width(MAX_WINDOW)-1:0]   i_q_count,
    output logic                                          o_valid,
    input  logic                                          i_ready,
    output logic [maf_pkg::MEAN_W-1:0]                    o_mean_value,
    output logic [maf_pkg::FILL_W-1:0]                    o_fill_count
);

    localparam int CW    = maf_pkg::count_width(MAX_WINDOW);
    localparam int SUM_W = maf_pkg::sum_width(MAX_WINDOW);
    localparam int STEP  = maf_pkg::DIV_STEP;
    localparam int DVD_W = SUM_W + maf_pkg::FRAC_W;
    localparam int ITER  = (DVD_W + STEP - 1) / STEP;
    localparam int PAD_W = ITER * STEP;
    localparam int IT_W  = $clog2(ITER + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [PAD_W-1:0]           r_dvd;
    logic [CW:0]                r_rem;
    logic [CW-1:0]              r_div;
    logic [IT_W-1:0]            r_cnt;
    logic                       r_ovalid;
    logic [maf_pkg::MEAN_W-1:0] r_mean;
    logic [maf_pkg::FILL_W-1:0] r_fill;
    logic [PAD_W-1:0]           n_dvd;
    logic [CW:0]                n_rem;
    logic                       out_free;

    assign o_q_pop      = (r_state == S_IDLE) && i_q_valid;
    assign out_free     = !r_ovalid || i_ready;
    assign o_valid      = r_ovalid;
    assign o_mean_value = r_mean;
    assign o_fill_count = r_fill;

    // Restoring division: shift a dividend bit into the remainder, subtract when it fits.
    always_comb begin
        logic [CW:0] trial;
        n_rem = r_rem;
        n_dvd = r_dvd;
        for (int k = 0; k < STEP; k++) begin
            trial = {n_rem[CW-1:0], n_dvd[PAD_W-1]};
            n_dvd = {n_dvd[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem    = trial - {1'b0, r_div};
                n_dvd[0] = 1'b1;
            end else begin
                n_rem = trial;
            end
        end
    end

    // Divider sequencing and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The result register fills from a finished division and empties on a handshake.
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_dvd   <= PAD_W'({i_q_sum, {maf_pkg::FRAC_W{1'b0}}});
                        r_div   <= i_q_count;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == IT_W'(ITER - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_mean  <= r_dvd[maf_pkg::MEAN_W-1:0];
                        r_fill  <= maf_pkg::FILL_W'(r_div);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The iteration count never runs past the last quotient digit.
    `MAWF_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= IT_W'(ITER), "divider count overrun")
    // A division is never started with a zero divisor.
    `MAWF_ASSERT_NEVER(a_div_zero, i_clk, i_rst_n, (r_state != S_IDLE) && (r_div == '0), "zero divisor")
    // A new result appears only out of a finished division.
    `MAWF_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ovalid) |-> $past(r_state) == S_DONE, "result without division")

endmodule

### hdl/moving_average_window_filter.sv
// ============================================================================
// Moving average window filter
// Mean of the most recent samples held in a ring, as unsigned Q16.8.
// ============================================================================
// Usage:
//   Input channel i_valid/o_ready carries one 16-bit sample word. Output
//   channel o_valid/i_ready carries one result word per sample: the mean in
//   Q16.8, truncated, and the number of samples it was taken over.
//   Writing i_cfg_data with i_cfg_we sets the window length (zero acts as one,
//   values above MAX_WINDOW saturate) and empties the history; write only
//   while the filter is idle.
//   The front end takes a new sample only while idle: on acceptance it reads
//   the oldest ring entry, and in its update state it writes the new sample
//   and updates the running sum. The back end divides 4 quotient bits per
//   cycle and takes a new word from the queue only after its last result has
//   gone to the output register. The divider sets the sustained rate.
//   A two-word queue and the output register let the front end keep taking
//   samples while the receiver stalls; once both fill, o_ready drops.
//   After reset the window length is 5 and the history is empty; no
//   clearing pass is needed.
// ============================================================================
module moving_average_window_filter #(
    parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [maf_pkg::WL_W-1:0]     i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [maf_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [maf_pkg::MEAN_W-1:0]   o_mean_value,
    output logic [maf_pkg::FILL_W-1:0]   o_fill_count
);

    localparam int CW    = maf_pkg::count_width(MAX_WINDOW);
    localparam int SUM_W = maf_pkg::sum_width(MAX_WINDOW);
    localparam int QW    = SUM_W + CW;

    logic             q_room;
    logic             q_push;
    logic [SUM_W-1:0] push_sum;
    logic [CW-1:0]    push_count;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_data;

    // Front end: sample ring and running sum.
    maf_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .i_q_room   (q_room),
        .o_q_push   (q_push),
        .o_q_sum    (push_sum),
        .o_q_count  (push_count)
    );

    // Queue between the two ends.
    maf_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_room  (q_room),
        .i_data  ({push_sum, push_count}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    // Back end: divider and output register.
    maf_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_q_sum      (q_data[QW-1:CW]),
        .i_q_count    (q_data[CW-1:0]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mean_value (o_mean_value),
        .o_fill_count (o_fill_count)
    );

endmodule
